[design/pvff_pkg.sv]
// Shared types, fixed-point constants and state encodings for the polygon
// vector form factor block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvff_pkg;

   localparam int FracBits = 14;
   localparam int CompW    = 16;
   localparam int AccW     = 21;
   localparam int SumW     = AccW + 6;
   localparam int MulW     = 34;
   localparam int ProdW    = 2 * MulW;
   localparam int FitW     = 30;
   localparam int YW       = FitW + 1;
   localparam int AW       = FitW + 1;
   localparam int VW       = 16;
   localparam int RcpW     = FracBits + 6;
   localparam int TW       = RcpW + 2;
   localparam int SqW      = 2 * FracBits + 1;
   localparam int DivNumW  = 46;
   localparam int DivDenW  = 34;
   localparam int DivCntW  = $clog2(DivNumW + 1);
   localparam int RootW    = 31;
   localparam int RadW     = 2 * RootW;
   localparam int RootCntW = $clog2(RootW + 1);
   localparam int RadShift = 60 - 2 * FracBits;

   localparam logic [MulW-1:0] FitA0 = 34'd917403404;
   localparam logic [MulW-1:0] FitA1 = 34'd533129459;
   localparam logic [MulW-1:0] FitA2 = 34'd15591386;
   localparam logic [MulW-1:0] FitB0 = 34'd3669613615;
   localparam logic [MulW-1:0] FitB1 = 34'd4468561704;

   localparam logic [RcpW-1:0]    RcpLimit = '1;
   localparam logic [DivNumW-1:0] RcpNum   = DivNumW'(1) << (FracBits + 29);
   localparam logic [SqW-1:0]     SqOne    = SqW'(1) << (2 * FracBits);

   localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
   localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

   typedef logic signed [CompW-1:0] comp_type;
   typedef logic signed [AccW-1:0]  acc_type;

   typedef struct packed {
      logic start;
      logic clear;
   } edge_ctl_type;

   typedef struct packed {
      logic done;
      logic sat;
   } edge_sts_type;

   typedef enum logic [4:0] {
      E_IDLE, E_DOT0, E_DOT1, E_DOT2, E_DOT3, E_CLAMP,
      E_FIT0, E_FIT1, E_FIT2, E_FIT3, E_VDIV,
      E_SQR0, E_SQR1, E_ROOT, E_RDIV,
      E_CR0, E_CR1, E_CR2, E_CR3
   } edge_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_RUN1_GO, T_RUN1, T_RUN2_GO, T_RUN2, T_EMIT
   } top_state_type;

endpackage
`default_nettype wire

[design/pvff_req_if.sv]
// Vertex input channel: valid/ready handshake with the vertex payload.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pvff_req_if;
   import pvff_pkg::*;
   logic     valid;
   logic     ready;
   comp_type vert_x;
   comp_type vert_y;
   comp_type vert_z;
   logic     last_vertex;
   modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
   modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface
`default_nettype wire

[design/pvff_rsp_if.sv]
// Result channel: valid/ready handshake with the summed vector and flag.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pvff_rsp_if;
   import pvff_pkg::*;
   logic    valid;
   logic    ready;
   acc_type sum_x;
   acc_type sum_y;
   acc_type sum_z;
   logic    saturated;
   modport source (output valid, sum_x, sum_y, sum_z, saturated, input ready);
   modport sink   (input valid, sum_x, sum_y, sum_z, saturated, output ready);
endinterface
`default_nettype wire

[design/pvff_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvff_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pvff_pkg::DivNumW-1:0]  num,
   input  logic [pvff_pkg::DivDenW-1:0]  den,
   output logic                          done,
   output logic [pvff_pkg::DivNumW-1:0]  quot
);
   import pvff_pkg::*;

   logic [DivNumW-1:0] sh_ff, sh_in;
   logic [DivDenW:0]   rem_ff, rem_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivDenW:0]   rem_sh;
   logic [DivDenW+1:0] diff;
   logic               ge;

   always_comb begin
      rem_sh  = {rem_ff[DivDenW-1:0], sh_ff[DivNumW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      ge      = ~diff[DivDenW+1];
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[DivNumW-2:0], ge};
         rem_in = ge ? diff[DivDenW:0] : rem_sh;
         cnt_in = cnt_ff + DivCntW'(1);
         if (cnt_ff == DivCntW'(DivNumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = sh_ff;
endmodule
`default_nettype wire

[design/pvff_isqrt.sv]
// Digit-serial integer square root: two radicand bits, one root bit a cycle.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvff_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pvff_pkg::RadW-1:0]   rad,
   output logic                        done,
   output logic [pvff_pkg::RootW-1:0]  root
);
   import pvff_pkg::*;

   logic [RadW-1:0]     rad_ff, rad_in;
   logic [RootW-1:0]    root_ff, root_in;
   logic [RootW+1:0]    rem_ff, rem_in;
   logic [RootCntW-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [RootW+3:0]    rem_sh;
   logic [RootW+4:0]    diff;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RadW-1:RadW-2]};
      diff    = {1'b0, rem_sh} - {3'b000, root_ff, 2'b01};
      ge      = ~diff[RootW+4];
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RadW-3:0], 2'b00};
         root_in = {root_ff[RootW-2:0], ge};
         rem_in  = ge ? diff[RootW+1:0] : rem_sh[RootW+1:0];
         cnt_in  = cnt_ff + RootCntW'(1);
         if (cnt_ff == RootCntW'(RootW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

[design/pvff_edge.sv]
// Edge sequencer: one shared multiplier, the fit, reciprocal and cross terms,
// and the saturating accumulator. Depends on pvff_pkg, pvff_div, pvff_isqrt.
`timescale 1ns / 1ps
`default_nettype none
module pvff_edge (
   input  logic                   clock,
   input  logic                   reset,
   input  pvff_pkg::edge_ctl_type ctl,
   input  pvff_pkg::comp_type     p [3],
   input  pvff_pkg::comp_type     c [3],
   output pvff_pkg::edge_sts_type sts,
   output pvff_pkg::acc_type      acc [3]
);
   import pvff_pkg::*;

   edge_state_type state_ff, state_in;
   logic [1:0]     k_ff;
   acc_type        acc_ff [3];
   logic           sat_ff;

   comp_type              p_ff [3];
   comp_type              c_ff [3];
   logic signed [MulW-1:0]  dot_ff;
   logic signed [CompW-1:0] x_ff;
   logic [YW-1:0]           y30_ff;
   logic [AW-1:0]           a30_ff;
   logic [VW-1:0]           v_ff;
   logic signed [TW-1:0]    t_ff;
   logic signed [32:0]      tmp_ff;
   logic signed [ProdW-1:0] mul_ff, mul_in;

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic [1:0]              ia, ib;
   logic [MulW-1:0]         fit_hi;
   logic [MulW-1:0]         b30;
   logic signed [MulW-1:0]  xr;
   logic signed [MulW-1:0]  cr;
   logic [SqW-1:0]          sq;
   logic signed [ProdW-1:0] term;
   logic signed [SumW-1:0]  sum;
   logic [RcpW-1:0]         rcp;
   logic                    rcp_sat;

   logic                  div_start, div_done;
   logic [DivNumW-1:0]    div_num, div_quot;
   logic [DivDenW-1:0]    div_den;
   logic                  sqrt_start, sqrt_done;
   logic [RadW-1:0]       sqrt_rad;
   logic [RootW-1:0]      sqrt_root;

   pvff_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   pvff_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (sqrt_rad),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // shared datapath terms
   always_comb begin
      ia      = (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
      ib      = (k_ff == 2'd0) ? 2'd2 : k_ff - 2'd1;
      fit_hi  = mul_ff[FitW+MulW-1:FitW];
      b30     = FitB0 + fit_hi;
      xr      = (dot_ff + MulW'(1 << (FracBits - 1))) >>> FracBits;
      cr      = MulW'(tmp_ff) - MulW'($signed(mul_ff[32:0]));
      sq      = SqOne - mul_ff[SqW-1:0];
      term    = (mul_ff + ProdW'(64'd1 << (2 * FracBits - 1))) >>> (2 * FracBits);
      sum     = SumW'(acc_ff[k_ff]) + SumW'(term);
      rcp_sat = (div_quot[DivNumW-1:RcpW] != '0);
      rcp     = rcp_sat ? RcpLimit : div_quot[RcpW-1:0];
      mul_in  = mul_a * mul_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE:  if (ctl.start) state_in = E_DOT0;
         E_DOT0:  state_in = E_DOT1;
         E_DOT1:  state_in = E_DOT2;
         E_DOT2:  state_in = E_DOT3;
         E_DOT3:  state_in = E_CLAMP;
         E_CLAMP: state_in = E_FIT0;
         E_FIT0:  state_in = E_FIT1;
         E_FIT1:  state_in = E_FIT2;
         E_FIT2:  state_in = E_FIT3;
         E_FIT3:  state_in = E_VDIV;
         E_VDIV: begin
            if (div_done) state_in = (x_ff > 16'sd0) ? E_CR0 : E_SQR0;
         end
         E_SQR0:  state_in = E_SQR1;
         E_SQR1:  state_in = E_ROOT;
         E_ROOT: begin
            if (sqrt_done) state_in = (sqrt_root == '0) ? E_CR0 : E_RDIV;
         end
         E_RDIV:  if (div_done) state_in = E_CR0;
         E_CR0:   state_in = E_CR1;
         E_CR1:   state_in = E_CR2;
         E_CR2:   state_in = E_CR3;
         E_CR3:   state_in = (k_ff == 2'd2) ? E_IDLE : E_CR0;
         default: state_in = E_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      sqrt_start = 1'b0;
      sqrt_rad   = '0;
      sts.done   = 1'b0;
      sts.sat    = sat_ff;
      unique case (state_ff)
         E_DOT0: begin
            mul_a = MulW'(p_ff[0]);
            mul_b = MulW'(c_ff[0]);
         end
         E_DOT1: begin
            mul_a = MulW'(p_ff[1]);
            mul_b = MulW'(c_ff[1]);
         end
         E_DOT2: begin
            mul_a = MulW'(p_ff[2]);
            mul_b = MulW'(c_ff[2]);
         end
         E_FIT0: begin
            mul_a = $signed(FitA2);
            mul_b = $signed({3'b000, y30_ff});
         end
         E_FIT1: begin
            mul_a = $signed(FitA1 + fit_hi);
            mul_b = $signed({3'b000, y30_ff});
         end
         E_FIT2: begin
            mul_a = $signed(FitB1 + {3'b000, y30_ff});
            mul_b = $signed({3'b000, y30_ff});
         end
         E_FIT3: begin
            div_start = 1'b1;
            div_num   = (DivNumW'(a30_ff) << FracBits) + DivNumW'(b30 >> 1);
            div_den   = b30;
         end
         E_SQR0: begin
            mul_a = MulW'(x_ff);
            mul_b = MulW'(x_ff);
         end
         E_SQR1: begin
            sqrt_start = 1'b1;
            sqrt_rad   = RadW'(sq) << RadShift;
         end
         E_ROOT: begin
            if (sqrt_done && sqrt_root != '0) begin
               div_start = 1'b1;
               div_num   = RcpNum + DivNumW'(sqrt_root >> 1);
               div_den   = DivDenW'(sqrt_root);
            end
         end
         E_CR0: begin
            mul_a = MulW'(p_ff[ia]);
            mul_b = MulW'(c_ff[ib]);
         end
         E_CR1: begin
            mul_a = MulW'(p_ff[ib]);
            mul_b = MulW'(c_ff[ia]);
         end
         E_CR2: begin
            mul_a = cr;
            mul_b = MulW'(t_ff);
         end
         E_CR3:   sts.done = (k_ff == 2'd2);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         k_ff     <= '0;
         sat_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (ctl.clear) begin
            sat_ff <= 1'b0;
            for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
         end
         case (state_ff)
            E_IDLE: k_ff <= '0;
            E_ROOT: if (sqrt_done && sqrt_root == '0) sat_ff <= 1'b1;
            E_RDIV: if (div_done && rcp_sat) sat_ff <= 1'b1;
            E_CR3: begin
               k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
               if (sum > SumW'(AccMax)) begin
                  acc_ff[k_ff] <= AccMax;
                  sat_ff       <= 1'b1;
               end else if (sum < SumW'(AccMin)) begin
                  acc_ff[k_ff] <= AccMin;
                  sat_ff       <= 1'b1;
               end else begin
                  acc_ff[k_ff] <= sum[AccW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      case (state_ff)
         E_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) begin
                  p_ff[i] <= p[i];
                  c_ff[i] <= c[i];
               end
            end
         end
         E_DOT1: dot_ff <= mul_ff[MulW-1:0];
         E_DOT2: dot_ff <= dot_ff + mul_ff[MulW-1:0];
         E_DOT3: dot_ff <= dot_ff + mul_ff[MulW-1:0];
         E_CLAMP: begin
            if (xr > MulW'(1 << FracBits)) begin
               x_ff   <= CompW'(1 << FracBits);
               y30_ff <= YW'(1) << FitW;
            end else if (xr < -MulW'(1 << FracBits)) begin
               x_ff   <= -CompW'(1 << FracBits);
               y30_ff <= YW'(1) << FitW;
            end else begin
               x_ff   <= xr[CompW-1:0];
               y30_ff <= YW'(xr[MulW-1] ? -xr : xr) << (FitW - FracBits);
            end
         end
         E_FIT2: a30_ff <= AW'(FitA0 + fit_hi);
         E_VDIV: begin
            if (div_done) begin
               v_ff <= div_quot[VW-1:0];
               t_ff <= $signed({{(TW-VW){1'b0}}, div_quot[VW-1:0]});
            end
         end
         E_ROOT: begin
            if (sqrt_done && sqrt_root == '0)
               t_ff <= $signed({2'b00, RcpLimit}) - $signed({{(TW-VW){1'b0}}, v_ff});
         end
         E_RDIV: begin
            if (div_done)
               t_ff <= $signed({2'b00, rcp}) - $signed({{(TW-VW){1'b0}}, v_ff});
         end
         E_CR1: tmp_ff <= $signed(mul_ff[32:0]);
         default: ;
      endcase
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

[design/polygon_vector_form_factor_top.sv]
// Polygon vector form factor, one vertex per transfer, sum out on the last.
// An edge with a positive dot product runs the bit-serial divider once; any other
// edge also runs the bit-serial square root and, unless the root is zero, a
// second divide. A last vertex runs its own edge, if it is not the first, and the
// closing edge, then loads the output register. Synchronous reset clears the
// sum, the flag and the polygon state; vertex stores are written before use.
`timescale 1ns / 1ps
`default_nettype none
module polygon_vector_form_factor_top (
   input  logic       clock,
   input  logic       reset,
   pvff_req_if.sink   req_chan,
   pvff_rsp_if.source rsp_chan
);
   import pvff_pkg::*;

   top_state_type state_ff, state_in;
   logic          in_poly_ff;
   logic          rsp_valid_ff;
   comp_type      first_ff [3];
   comp_type      prev_ff [3];
   comp_type      cur_ff [3];
   logic          last_ff;
   acc_type       sum_x_ff, sum_y_ff, sum_z_ff;
   logic          sat_out_ff;

   edge_ctl_type  ctl;
   edge_sts_type  sts;
   comp_type      edge_p [3];
   comp_type      edge_c [3];
   acc_type       acc [3];
   logic          accept;
   logic          load;

   pvff_edge u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .p     (edge_p),
      .c     (edge_c),
      .sts   (sts),
      .acc   (acc)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign load   = (state_ff == T_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (in_poly_ff)              state_in = T_RUN1_GO;
               else if (req_chan.last_vertex) state_in = T_RUN2_GO;
            end
         end
         T_RUN1_GO: state_in = T_RUN1;
         T_RUN1:    if (sts.done) state_in = last_ff ? T_RUN2_GO : T_IDLE;
         T_RUN2_GO: state_in = T_RUN2;
         T_RUN2:    if (sts.done) state_in = T_EMIT;
         T_EMIT:    if (load) state_in = T_IDLE;
         default:   state_in = T_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ctl.start      = 1'b0;
      ctl.clear      = load;
      edge_p         = cur_ff;
      edge_c         = first_ff;
      unique case (state_ff)
         T_IDLE: req_chan.ready = 1'b1;
         T_RUN1_GO: begin
            ctl.start = 1'b1;
            edge_p    = prev_ff;
            edge_c    = cur_ff;
         end
         T_RUN2_GO: ctl.start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         in_poly_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) in_poly_ff <= 1'b1;
         if (load) begin
            in_poly_ff   <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff[0] <= req_chan.vert_x;
         cur_ff[1] <= req_chan.vert_y;
         cur_ff[2] <= req_chan.vert_z;
         last_ff   <= req_chan.last_vertex;
         if (!in_poly_ff) begin
            first_ff[0] <= req_chan.vert_x;
            first_ff[1] <= req_chan.vert_y;
            first_ff[2] <= req_chan.vert_z;
            prev_ff[0]  <= req_chan.vert_x;
            prev_ff[1]  <= req_chan.vert_y;
            prev_ff[2]  <= req_chan.vert_z;
         end
      end
      // advance the previous vertex once its edge is in the sum
      if (state_ff == T_RUN1 && sts.done) prev_ff <= cur_ff;
      if (load) begin
         sum_x_ff   <= acc[0];
         sum_y_ff   <= acc[1];
         sum_z_ff   <= acc[2];
         sat_out_ff <= sts.sat;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.sum_x     = sum_x_ff;
   assign rsp_chan.sum_y     = sum_y_ff;
   assign rsp_chan.sum_z     = sum_z_ff;
   assign rsp_chan.saturated = sat_out_ff;
endmodule
`default_nettype wire
